// ----- src/hbeg_pkg.sv -----
// Shared types, constants and ramp selection helpers of the heartbeat envelope generator.
package hbeg_pkg;

  localparam int unsigned DUR_W  = 16;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned STEP_W = 3;

  // Last step of the eight-step serial multiply and divide.
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  // Ramp indices; RAMP_COUNT is the rest phase after the four ramps.
  localparam logic [IDX_W-1:0] RAMP_RISE_ONE = 3'd0;
  localparam logic [IDX_W-1:0] RAMP_FALL_ONE = 3'd1;
  localparam logic [IDX_W-1:0] RAMP_RISE_TWO = 3'd2;
  localparam logic [IDX_W-1:0] RAMP_FALL_TWO = 3'd3;
  localparam logic [IDX_W-1:0] RAMP_COUNT    = 3'd4;

  // Configuration register indices.
  localparam logic [IDX_W-1:0] REG_BEAT_PERIOD = 3'd0;
  localparam logic [IDX_W-1:0] REG_RISE_ONE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_FALL_ONE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RISE_TWO    = 3'd3;
  localparam logic [IDX_W-1:0] REG_FALL_TWO    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PEAK_ONE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_PEAK_TWO    = 3'd6;

  // Register values after reset.
  localparam logic [DUR_W-1:0] RST_BEAT_PERIOD = 16'd1000;
  localparam logic [DUR_W-1:0] RST_RISE_ONE    = 16'd100;
  localparam logic [DUR_W-1:0] RST_FALL_ONE    = 16'd80;
  localparam logic [DUR_W-1:0] RST_RISE_TWO    = 16'd80;
  localparam logic [DUR_W-1:0] RST_FALL_TWO    = 16'd150;
  localparam logic [LVL_W-1:0] RST_PEAK_ONE    = 8'd255;
  localparam logic [LVL_W-1:0] RST_PEAK_TWO    = 8'd200;

  typedef struct packed {
    logic [DUR_W-1:0] beat_period;
    logic [DUR_W-1:0] rise_one;
    logic [DUR_W-1:0] fall_one;
    logic [DUR_W-1:0] rise_two;
    logic [DUR_W-1:0] fall_two;
    logic [LVL_W-1:0] peak_one;
    logic [LVL_W-1:0] peak_two;
  } cfg_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PASS,
    SEQ_CALC,
    SEQ_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV,
    AR_DONE
  } arith_state_e;

  typedef struct packed {
    logic             start;
    logic [LVL_W-1:0] start_level;
    logic [LVL_W-1:0] target;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] level;
  } arith_rsp_t;

  function automatic logic [DUR_W-1:0] ramp_duration(cfg_t cfg, logic [IDX_W-1:0] idx);
    logic [DUR_W-1:0] dur;
    case (idx)
      RAMP_RISE_ONE: dur = cfg.rise_one;
      RAMP_FALL_ONE: dur = cfg.fall_one;
      RAMP_RISE_TWO: dur = cfg.rise_two;
      default:       dur = cfg.fall_two;
    endcase
    return dur;
  endfunction

  function automatic logic [LVL_W-1:0] ramp_target(cfg_t cfg, logic [IDX_W-1:0] idx);
    logic [LVL_W-1:0] tgt;
    case (idx)
      RAMP_RISE_ONE: tgt = cfg.peak_one;
      RAMP_RISE_TWO: tgt = cfg.peak_two;
      default:       tgt = '0;
    endcase
    return tgt;
  endfunction

endpackage

// ----- src/hbeg_arith.sv -----
// Bit-serial multiply followed by restoring divide for one ramp interpolation.
module hbeg_arith import hbeg_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  arith_req_t           req_i,
  input  logic [TIME_BITS-1:0] elapsed_i,
  input  logic [DUR_W-1:0]     duration_i,
  output arith_rsp_t           rsp_o
);

  localparam int unsigned PROD_W = TIME_BITS + LVL_W;

  arith_state_e      state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              falling_q, falling_d;
  logic [LVL_W-1:0]  start_q, start_d;
  logic [DUR_W-1:0]  dur_q, dur_d;
  logic [LVL_W-1:0]  mplier_q, mplier_d;
  logic [PROD_W-1:0] mcand_q, mcand_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [DUR_W-1:0]  rem_q, rem_d;
  logic [LVL_W-1:0]  lo_q, lo_d;
  logic [LVL_W-1:0]  quo_q, quo_d;

  logic              req_falling;
  logic [LVL_W-1:0]  req_delta;
  logic [PROD_W-1:0] acc_sum;
  logic [DUR_W:0]    trial;
  logic [DUR_W:0]    trial_diff;
  logic              trial_fits;
  logic              round_up;

  assign req_falling = req_i.target < req_i.start_level;
  assign req_delta   = req_falling ? (req_i.start_level - req_i.target)
                                   : (req_i.target - req_i.start_level);
  assign acc_sum     = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign trial       = {rem_q, lo_q[LVL_W-1]};
  assign trial_diff  = trial - {1'b0, dur_q};
  assign trial_fits  = trial >= {1'b0, dur_q};
  // A falling ramp rounds the decrement up, so the level is still floored.
  assign round_up    = falling_q && (rem_q != '0);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    falling_d = falling_q;
    start_d   = start_q;
    dur_d     = dur_q;
    mplier_d  = mplier_q;
    mcand_d   = mcand_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    lo_d      = lo_q;
    quo_d     = quo_q;
    rsp_o     = '0;
    case (state_q)
      AR_IDLE: begin
        if (req_i.start) begin
          falling_d = req_falling;
          start_d   = req_i.start_level;
          dur_d     = duration_i;
          mplier_d  = req_delta;
          mcand_d   = PROD_W'(elapsed_i);
          acc_d     = '0;
          cnt_d     = '0;
          state_d   = AR_MUL;
        end
      end
      AR_MUL: begin
        acc_d    = acc_sum;
        mplier_d = mplier_q >> 1;
        mcand_d  = mcand_q << 1;
        cnt_d    = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_LAST) begin
          // The quotient fits in eight bits, so the upper part is below the divisor.
          rem_d   = DUR_W'(acc_sum >> LVL_W);
          lo_d    = acc_sum[LVL_W-1:0];
          quo_d   = '0;
          cnt_d   = '0;
          state_d = AR_DIV;
        end
      end
      AR_DIV: begin
        rem_d = trial_fits ? DUR_W'(trial_diff) : DUR_W'(trial);
        lo_d  = lo_q << 1;
        quo_d = {quo_q[LVL_W-2:0], trial_fits};
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_LAST) begin
          state_d = AR_DONE;
        end
      end
      AR_DONE: begin
        rsp_o.done  = 1'b1;
        rsp_o.level = falling_q ? (start_q - quo_q - LVL_W'(round_up)) : (start_q + quo_q);
        state_d     = AR_IDLE;
      end
      default: begin
        state_d = AR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    falling_q <= falling_d;
    start_q   <= start_d;
    dur_q     <= dur_d;
    mplier_q  <= mplier_d;
    mcand_q   <= mcand_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    lo_q      <= lo_d;
    quo_q     <= quo_d;
  end

endmodule

// ----- src/hbeg_seq.sv -----
// Beat sequencer: ramp index, elapsed counters and per-tick control.
module hbeg_seq import hbeg_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_active_i,
  output logic                 in_stall_o,
  input  cfg_t                 cfg_i,
  output logic                 res_valid_o,
  output logic [LVL_W-1:0]     res_level_o,
  input  logic                 res_ready_i,
  output arith_req_t           arith_req_o,
  output logic [TIME_BITS-1:0] arith_elapsed_o,
  output logic [DUR_W-1:0]     arith_duration_o,
  input  arith_rsp_t           arith_rsp_i
);

  localparam int unsigned CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  seq_state_e           state_q, state_d;
  logic                 running_q, running_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TIME_BITS-1:0] ramp_el_q, ramp_el_d;
  logic [TIME_BITS-1:0] beat_el_q, beat_el_d;
  logic [LVL_W-1:0]     start_q, start_d;
  logic [LVL_W-1:0]     level_q, level_d;

  logic [DUR_W-1:0]     dur;
  logic [CMP_W-1:0]     ramp_el_x, beat_el_x, dur_x, period_x, ramp_left_x;
  logic                 in_ramp, ramp_over;
  logic [TIME_BITS-1:0] ramp_el_inc, beat_el_inc;

  assign dur         = ramp_duration(cfg_i, idx_q);
  assign ramp_el_x   = CMP_W'(ramp_el_q);
  assign beat_el_x   = CMP_W'(beat_el_q);
  assign dur_x       = CMP_W'(dur);
  assign period_x    = CMP_W'(cfg_i.beat_period);
  assign ramp_left_x = ramp_el_x - dur_x;
  assign in_ramp     = idx_q < RAMP_COUNT;
  assign ramp_over   = ramp_el_x >= dur_x;
  // Both counters stick at all ones.
  assign ramp_el_inc = (&ramp_el_q) ? ramp_el_q : ramp_el_q + TIME_BITS'(1);
  assign beat_el_inc = (&beat_el_q) ? beat_el_q : beat_el_q + TIME_BITS'(1);

  assign arith_elapsed_o  = ramp_el_q;
  assign arith_duration_o = dur;
  assign res_level_o      = level_q;

  always_comb begin
    state_d                 = state_q;
    running_d               = running_q;
    idx_d                   = idx_q;
    ramp_el_d               = ramp_el_q;
    beat_el_d               = beat_el_q;
    start_d                 = start_q;
    level_d                 = level_q;
    res_valid_o             = 1'b0;
    in_stall_o              = (state_q != SEQ_IDLE);
    arith_req_o.start       = 1'b0;
    arith_req_o.start_level = start_q;
    arith_req_o.target      = ramp_target(cfg_i, idx_q);
    case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          if (!in_active_i) begin
            running_d = 1'b0;
            idx_d     = RAMP_COUNT;
            ramp_el_d = '0;
            beat_el_d = '0;
            level_d   = '0;
            state_d   = SEQ_EMIT;
          end else begin
            if (!running_q) begin
              running_d = 1'b1;
              idx_d     = RAMP_RISE_ONE;
              ramp_el_d = '0;
              beat_el_d = '0;
              start_d   = '0;
            end
            state_d = SEQ_PASS;
          end
        end
      end
      SEQ_PASS: begin
        if (in_ramp && ramp_over) begin
          // Skip one finished ramp per cycle.
          start_d   = ramp_target(cfg_i, idx_q);
          ramp_el_d = TIME_BITS'(ramp_left_x);
          idx_d     = idx_q + IDX_W'(1);
        end else if (!in_ramp) begin
          level_d = '0;
          if (beat_el_x >= period_x) begin
            running_d = 1'b0;
          end
          ramp_el_d = ramp_el_inc;
          beat_el_d = beat_el_inc;
          state_d   = SEQ_EMIT;
        end else begin
          arith_req_o.start = 1'b1;
          state_d           = SEQ_CALC;
        end
      end
      SEQ_CALC: begin
        if (arith_rsp_i.done) begin
          level_d   = arith_rsp_i.level;
          ramp_el_d = ramp_el_inc;
          beat_el_d = beat_el_inc;
          state_d   = SEQ_EMIT;
        end
      end
      SEQ_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      running_q <= 1'b0;
      idx_q     <= RAMP_COUNT;
      ramp_el_q <= '0;
      beat_el_q <= '0;
      start_q   <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      idx_q     <= idx_d;
      ramp_el_q <= ramp_el_d;
      beat_el_q <= beat_el_d;
      start_q   <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

endmodule

// ----- src/heartbeat_envelope_generator_top.sv -----
// Top level of the heartbeat envelope generator: registers, output stage and wiring.
//
//   Channel  Direction  Handshake                  Payload
//   -------  ---------  -------------------------  ---------------------------
//   in       input      in_valid_i / in_stall_o    in_active_i   (1 bit)
//   out      output     out_valid_o / out_stall_i  out_level_o   (8 bits)
//   cfg      input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// With a free output register, an inactive request goes straight to the emit state, which
// loads the level into the output register. An active request in the rest phase gives
// level zero; one inside a ramp is interpolated. The sequencer skips each finished ramp
// in turn (up to four, at most three before a ramp that still runs), then the arithmetic
// unit runs a bit-serial multiply and a restoring divide, one quotient bit per cycle, and
// its done state hands the level back to the sequencer.
// Reset clears the beat state and loads the register defaults; no clearing pass.
// A finished level waits in the output register, so the next request is taken
// while out_stall_i holds the previous one.
module heartbeat_envelope_generator_top import hbeg_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_active_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LVL_W-1:0] out_level_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic                 out_valid_q, out_valid_d;
  logic [LVL_W-1:0]     out_level_q, out_level_d;
  logic                 out_free;

  logic                 res_valid;
  logic [LVL_W-1:0]     res_level;
  arith_req_t           arith_req;
  arith_rsp_t           arith_rsp;
  logic [TIME_BITS-1:0] arith_elapsed;
  logic [DUR_W-1:0]     arith_duration;

  // Configuration writes land directly; an unknown index leaves everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BEAT_PERIOD: cfg_d.beat_period = cfg_data_i;
        REG_RISE_ONE:    cfg_d.rise_one    = cfg_data_i;
        REG_FALL_ONE:    cfg_d.fall_one    = cfg_data_i;
        REG_RISE_TWO:    cfg_d.rise_two    = cfg_data_i;
        REG_FALL_TWO:    cfg_d.fall_two    = cfg_data_i;
        REG_PEAK_ONE:    cfg_d.peak_one    = cfg_data_i[LVL_W-1:0];
        REG_PEAK_TWO:    cfg_d.peak_two    = cfg_data_i[LVL_W-1:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_period <= RST_BEAT_PERIOD;
      cfg_q.rise_one    <= RST_RISE_ONE;
      cfg_q.fall_one    <= RST_FALL_ONE;
      cfg_q.rise_two    <= RST_RISE_TWO;
      cfg_q.fall_two    <= RST_FALL_TWO;
      cfg_q.peak_one    <= RST_PEAK_ONE;
      cfg_q.peak_two    <= RST_PEAK_TWO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The output register is free when empty or when its level leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      out_level_d = res_level;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_level_q <= out_level_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_level_o = out_level_q;

  // The sequencer tracks the beat and decides each tick's ramp.
  hbeg_seq #(
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_active_i      (in_active_i),
    .in_stall_o       (in_stall_o),
    .cfg_i            (cfg_q),
    .res_valid_o      (res_valid),
    .res_level_o      (res_level),
    .res_ready_i      (out_free),
    .arith_req_o      (arith_req),
    .arith_elapsed_o  (arith_elapsed),
    .arith_duration_o (arith_duration),
    .arith_rsp_i      (arith_rsp)
  );

  // The arithmetic unit turns elapsed time into a level within the current ramp.
  hbeg_arith #(
    .TIME_BITS (TIME_BITS)
  ) u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (arith_req),
    .elapsed_i  (arith_elapsed),
    .duration_i (arith_duration),
    .rsp_o      (arith_rsp)
  );

endmodule

// ----- src/hbeg_checker.sv -----
// Port-level checks of the heartbeat envelope generator and their binding.
module hbeg_checker import hbeg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             in_active_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [LVL_W-1:0] out_level_o
);

  // A stalled level stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_level_o))
    else $error("stalled output level changed or dropped");

  // Every accepted request keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a request without going busy");

  // An inactive tick on an empty output stage goes via SEQ_EMIT to level zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_active_i && !out_valid_o
      |-> ##2 (out_valid_o && (out_level_o == '0)))
    else $error("inactive tick did not give level zero");

endmodule

bind heartbeat_envelope_generator_top hbeg_checker u_hbeg_checker (.*);
